>>> rtl/blpg_pkg.sv
package blpg_pkg;

  // Fixed field widths
  localparam int COORD_W = 6;
  localparam int ADDR_W  = 14;
  localparam int FW_W    = 7;
  localparam int BPP_W   = 3;
  localparam int COLOR_W = 8;
  localparam int ERR_W   = 9;
  localparam int ROW_W   = 13;
  localparam int STRIDE_W = 10;

  // Frame size and longest line that one command may emit
  localparam int FRAME_DIM = 64;
  localparam logic [COORD_W-1:0] LEN_CAP = COORD_W'(FRAME_DIM - 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE      = 3'd4;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET     = 7'd64;
  localparam logic [BPP_W-1:0] BYTES_PER_PIXEL_RESET = 3'd3;

  // Configuration register contents
  typedef struct packed {
    logic [FW_W-1:0]    frame_width;
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic [COLOR_W-1:0] color_red;
    logic [COLOR_W-1:0] color_green;
    logic [COLOR_W-1:0] color_blue;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture command endpoints
    logic setup;       // octant, deltas, error term
    logic addr_row;    // row product and row stride
    logic addr_scale;  // start address and step deltas
    logic step;        // emit one pixel and advance
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic zero_len;
    logic last;
  } dp_stat_t;

endpackage

>>> rtl/blpg_if.sv
interface blpg_cmd_if;
  import blpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

interface blpg_pix_if;
  import blpg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [ADDR_W-1:0]  byte_address;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output byte_address,
                  output red, output green, output blue, output last_pixel,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input byte_address,
                input red, input green, input blue, input last_pixel,
                output ready);
endinterface

>>> rtl/blpg_ctrl.sv
module blpg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  blpg_pkg::dp_stat_t stat,
  output blpg_pkg::dp_cmd_t  cmd
);
  import blpg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROW,
    ST_SCALE,
    ST_RUN
  } state_t;

  state_t state;
  logic   out_free;

  // Output register can take a new pixel when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Datapath commands
  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) && in_valid;
    cmd.setup      = (state == ST_SETUP);
    cmd.addr_row   = (state == ST_ROW);
    cmd.addr_scale = (state == ST_SCALE);
    cmd.step       = (state == ST_RUN) && out_free;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A new pixel loads the output register; otherwise a transaction empties it
      if ((state == ST_RUN) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_SETUP;
        end
        ST_SETUP: begin
          if (stat.zero_len) state <= ST_IDLE;
          else state <= ST_ROW;
        end
        ST_ROW: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (out_free && stat.last) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A pixel only appears from the run state
  a_valid_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_RUN))
    else $error("pixel valid rose outside run state");

  // The last pixel of a line returns the controller to idle
  a_last_exits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && out_free && stat.last) |=> (state == ST_IDLE))
    else $error("controller stayed busy after last pixel");

endmodule

>>> rtl/blpg_dp.sv
module blpg_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  blpg_pkg::dp_cmd_t             cmd,
  output blpg_pkg::dp_stat_t            stat,
  input  blpg_pkg::cfg_t                cfg,
  input  logic [blpg_pkg::COORD_W-1:0]  start_x,
  input  logic [blpg_pkg::COORD_W-1:0]  start_y,
  input  logic [blpg_pkg::COORD_W-1:0]  end_x,
  input  logic [blpg_pkg::COORD_W-1:0]  end_y,
  output logic [blpg_pkg::COORD_W-1:0]  pixel_x,
  output logic [blpg_pkg::COORD_W-1:0]  pixel_y,
  output logic [blpg_pkg::ADDR_W-1:0]   byte_address,
  output logic [blpg_pkg::COLOR_W-1:0]  red,
  output logic [blpg_pkg::COLOR_W-1:0]  green,
  output logic [blpg_pkg::COLOR_W-1:0]  blue,
  output logic                          last_pixel
);
  import blpg_pkg::*;

  // Captured endpoints
  logic [COORD_W-1:0] x0, y0, x1, y1;

  // Line walker state
  logic [COORD_W-1:0]     major_pos, minor_pos, remaining;
  logic signed [ERR_W-1:0] error_term;
  logic [COORD_W:0]       inc_straight;
  logic signed [COORD_W+1:0] inc_diagonal;
  logic                   minor_step_negative, steep_mode;

  // Address state
  logic [ROW_W-1:0]    row_prod;
  logic [STRIDE_W-1:0] row_stride;
  logic [ADDR_W-1:0]   addr, major_delta, minor_delta;

  // Setup combinational terms
  logic [COORD_W-1:0] adx, ady, maj_a, min_a, maj_b, min_b;
  logic [COORD_W-1:0] maj0, min0, maj1, min1, dmaj, admin, len_c;
  logic               steep_c, swap_c, neg_c;

  // Step combinational terms
  logic [COORD_W-1:0] px, py;
  logic               err_pos;
  logic [ADDR_W-1:0]  minor_base;

  // Octant selection and endpoint ordering
  always_comb begin
    adx     = (x0 > x1) ? x0 - x1 : x1 - x0;
    ady     = (y0 > y1) ? y0 - y1 : y1 - y0;
    steep_c = !(ady < adx);
    maj_a   = steep_c ? y0 : x0;
    min_a   = steep_c ? x0 : y0;
    maj_b   = steep_c ? y1 : x1;
    min_b   = steep_c ? x1 : y1;
    swap_c  = maj_a > maj_b;
    maj0    = swap_c ? maj_b : maj_a;
    min0    = swap_c ? min_b : min_a;
    maj1    = swap_c ? maj_a : maj_b;
    min1    = swap_c ? min_a : min_b;
    dmaj    = maj1 - maj0;
    neg_c   = min1 < min0;
    admin   = neg_c ? min0 - min1 : min1 - min0;
    len_c   = (dmaj > LEN_CAP) ? LEN_CAP : dmaj;
  end

  // Current pixel and error decision
  assign px         = steep_mode ? minor_pos : major_pos;
  assign py         = steep_mode ? major_pos : minor_pos;
  assign err_pos    = !error_term[ERR_W-1] && (error_term != '0);
  assign minor_base = steep_mode ? {{(ADDR_W-BPP_W){1'b0}}, cfg.bytes_per_pixel}
                                 : {{(ADDR_W-STRIDE_W){1'b0}}, row_stride};

  // Zero length is judged on the captured command during setup
  assign stat.zero_len = (len_c == '0);
  assign stat.last     = (remaining == COORD_W'(1));

  // Command capture, setup and pixel walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0 <= start_x;
      y0 <= start_y;
      x1 <= end_x;
      y1 <= end_y;
    end

    if (cmd.setup) begin
      steep_mode          <= steep_c;
      minor_step_negative <= neg_c;
      major_pos           <= maj0;
      minor_pos           <= min0;
      remaining           <= len_c;
      inc_straight        <= {admin, 1'b0};
      inc_diagonal        <= $signed({1'b0, admin, 1'b0}) - $signed({1'b0, dmaj, 1'b0});
      error_term          <= $signed({2'b00, admin, 1'b0}) - $signed({3'b000, dmaj});
    end

    // First multiply: row product and row stride
    if (cmd.addr_row) begin
      row_prod   <= ROW_W'(py * cfg.frame_width) + {{(ROW_W-COORD_W){1'b0}}, px};
      row_stride <= STRIDE_W'(cfg.frame_width * cfg.bytes_per_pixel);
    end

    // Second multiply: start address and per-axis address steps
    if (cmd.addr_scale) begin
      addr        <= ADDR_W'(row_prod * cfg.bytes_per_pixel);
      major_delta <= steep_mode ? {{(ADDR_W-STRIDE_W){1'b0}}, row_stride}
                                : {{(ADDR_W-BPP_W){1'b0}}, cfg.bytes_per_pixel};
      minor_delta <= minor_step_negative ? ADDR_W'(0) - minor_base : minor_base;
    end

    // Emit the current pixel, then advance one major step
    if (cmd.step) begin
      pixel_x      <= px;
      pixel_y      <= py;
      byte_address <= addr;
      red          <= cfg.color_red;
      green        <= cfg.color_green;
      blue         <= cfg.color_blue;
      last_pixel   <= stat.last;

      major_pos <= major_pos + COORD_W'(1);
      remaining <= remaining - COORD_W'(1);
      if (err_pos) begin
        minor_pos  <= minor_step_negative ? minor_pos - COORD_W'(1)
                                          : minor_pos + COORD_W'(1);
        error_term <= error_term + {inc_diagonal[COORD_W+1], inc_diagonal};
        addr       <= addr + major_delta + minor_delta;
      end else begin
        error_term <= error_term + $signed({2'b00, inc_straight});
        addr       <= addr + major_delta;
      end
    end
  end

  // The walker never steps past the end of a line
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (remaining != '0))
    else $error("pixel step with no pixels left");

  // The last flag follows the final remaining pixel
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> (last_pixel == ($past(remaining) == COORD_W'(1))))
    else $error("last flag does not match remaining count");

endmodule

>>> rtl/bresenham_line_pixel_generator_core.sv
// Line command to pixel writes, one command in flight at a time.
// The first pixel is presented after the setup, row and scale states, from the output register loaded in the run state.
// Pixels come one per cycle from the error-term step unit while pix.ready does
// not stall the output; a zero-length line returns to idle without a pixel.
// Reset (rst, synchronous): controller idle, output invalid, configuration registers to defaults.
module bresenham_line_pixel_generator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [blpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blpg_pkg::CFG_DATA_W-1:0] cfg_data,
  blpg_cmd_if.sink                        cmd,
  blpg_pix_if.source                      pix
);
  import blpg_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= FRAME_WIDTH_RESET;
      cfg.bytes_per_pixel <= BYTES_PER_PIXEL_RESET;
      cfg.color_red       <= '0;
      cfg.color_green     <= '0;
      cfg.color_blue      <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[FW_W-1:0];
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_COLOR_RED:       cfg.color_red       <= cfg_data[COLOR_W-1:0];
        REG_COLOR_GREEN:     cfg.color_green     <= cfg_data[COLOR_W-1:0];
        REG_COLOR_BLUE:      cfg.color_blue      <= cfg_data[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  blpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_ready (pix.ready),
    .out_valid (pix.valid),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Line walker and address datapath
  blpg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .cfg          (cfg),
    .start_x      (cmd.start_x),
    .start_y      (cmd.start_y),
    .end_x        (cmd.end_x),
    .end_y        (cmd.end_y),
    .pixel_x      (pix.pixel_x),
    .pixel_y      (pix.pixel_y),
    .byte_address (pix.byte_address),
    .red          (pix.red),
    .green        (pix.green),
    .blue         (pix.blue),
    .last_pixel   (pix.last_pixel)
  );

endmodule
